/* rtl/core/ihex_pkg.sv */
// shared types and constants of the hex record parser
package ihex_pkg;

    // character and digit decoding
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] DIGIT_LOW_MASK = 8'h0F;
    localparam logic [7:0] DIGIT_ALPHA    = 8'h40;
    localparam logic [4:0] DIGIT_ALPHA_ADJ = 5'd9;
    localparam logic [7:0] BYTE_MASK      = 8'hFF;

    // positions inside a line, counted from the colon
    localparam int unsigned POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;
    localparam logic [POS_W-1:0] POS_START      = 10'd0;
    localparam logic [POS_W-1:0] POS_COUNT_DONE = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_DONE  = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE_DONE  = 10'd8;
    localparam logic [POS_W-1:0] POS_DATA_FIRST = 10'd9;
    localparam logic [POS_W-1:0] POS_BASE_DONE  = 10'd12;
    localparam logic [POS_W-1:0] LEN_HEADER     = 10'd9;
    localparam logic [POS_W-1:0] LEN_BASE_REC   = 10'd13;
    localparam logic [POS_W-1:0] LEN_DATA_EXTRA = 10'd11;

    // record types
    localparam logic [7:0] REC_DATA     = 8'h00;
    localparam logic [7:0] REC_EOF      = 8'h01;
    localparam logic [7:0] REC_SEGMENT  = 8'h02;
    localparam logic [7:0] REC_EXTENDED = 8'h04;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // line status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_COLON = 2'd1;
    localparam logic [1:0] ST_CUT_OFF  = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    typedef struct packed {
        logic        kind;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic        end_seen;
        logic        last_result;
    } result_t;

endpackage

/* rtl/core/ihex_if.sv */
// valid/ready channels for characters in and results out
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       line_end;

    modport source (output valid, character, line_end, input ready);
    modport sink   (input valid, character, line_end, output ready);
endinterface

interface ihex_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic        end_seen;
    logic        last_result;

    modport source (output valid, kind, byte_address, data_byte, status, record_type,
                    byte_count, end_seen, last_result, input ready);
    modport sink   (input valid, kind, byte_address, data_byte, status, record_type,
                    byte_count, end_seen, last_result, output ready);
endinterface

/* rtl/core/ihex_result_fifo.sv */
// small result queue, up to two writes and one read per cycle
module ihex_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        wr_count,
    input  ihex_pkg::result_t wr_first,
    input  ihex_pkg::result_t wr_second,
    input  logic              rd_en,
    output ihex_pkg::result_t rd_data,
    output logic              rd_valid,
    output logic              has_room
);
    import ihex_pkg::*;

    result_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   level_reg;
    logic [QPTR_W:0]   level_next;
    logic              pop;

    // status towards both sides
    assign rd_valid = (level_reg != '0);
    assign has_room = (level_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_en & rd_valid;

    // pointer and fill level arithmetic
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + QPTR_W'(wr_count);
        rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
        level_next   = level_reg + (QPTR_W+1)'(wr_count) - (QPTR_W+1)'(pop);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage, first beat at the write pointer, second just after it
    always_ff @(posedge clk)
    begin
        if (wr_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_first;
        end
        if (wr_count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= wr_second;
        end
    end

endmodule

/* rtl/core/intel_hex_record_parser.sv */
// Intel HEX record parser: takes one character per cycle while the result queue has room
// and returns data bytes and a status beat per line. A character is decoded in the cycle
// it is accepted and its results are registered in the result queue. Every character that
// yields at most one result can follow the previous one in the next cycle; the last
// character of a data line that ends on the second digit of a data byte (a line cut off
// before its checksum) yields two beats, and the result queue (four entries) then drains
// at one beat per cycle while the result channel is ready, so input stalls only when the
// queue holds more than two beats. No clearing pass follows reset.
module intel_hex_record_parser (
    input  logic           clk,
    input  logic           rst_n,
    ihex_char_if.sink      chars,
    ihex_result_if.source  results
);
    import ihex_pkg::*;

    logic             accept;
    logic             queue_room;
    logic [1:0]       wr_count;
    result_t          wr_first;
    result_t          wr_second;
    result_t          head;
    logic             head_valid;

    // per-line and persistent state
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic             failed_reg, failed_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      addr_reg,  addr_next;
    logic [7:0]       type_reg,  type_next;
    logic [7:0]       sum_reg,   sum_next;
    logic [15:0]      acc_reg,   acc_next;
    logic [15:0]      seg_reg,   seg_next;
    logic [15:0]      ext_reg,   ext_next;
    logic [7:0]       index_reg, index_next;
    logic             end_reg,   end_next;

    // step working values
    logic [4:0]       digit;
    logic [15:0]      acc_shift;
    logic [POS_W-1:0] pos_off;
    logic [POS_W-2:0] pair;
    logic [7:0]       pair_byte;
    logic [POS_W-1:0] data_len;
    logic [31:0]      base_addr;
    logic             emit_data;
    logic [1:0]       line_status;
    result_t          data_res;
    result_t          status_res;

    assign accept      = chars.valid & chars.ready;
    assign chars.ready = queue_room;

    // digit value and shifted field accumulator
    always_comb
    begin
        digit = 5'(chars.character & DIGIT_LOW_MASK)
              + (((chars.character & DIGIT_ALPHA) != 8'h00) ? DIGIT_ALPHA_ADJ : 5'd0);
        acc_shift = {acc_reg[11:0], 4'b0000} | 16'(digit);
        pos_off   = pos_reg - POS_DATA_FIRST;
        pair      = pos_off[POS_W-1:1];
        pair_byte = acc_shift[7:0] & BYTE_MASK;
        base_addr = {12'h000, seg_reg, 4'h0} + {ext_reg, 16'h0000}
                  + {16'h0000, addr_reg} + {24'h000000, index_reg};
    end

    // record decode for one character
    always_comb
    begin
        pos_next    = pos_reg;
        failed_next = failed_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        acc_next    = acc_reg;
        seg_next    = seg_reg;
        ext_next    = ext_reg;
        index_next  = index_reg;
        end_next    = end_reg;
        emit_data   = 1'b0;
        line_status = ST_OK;
        data_len    = 10'({1'b0, count_reg, 1'b0}) + LEN_DATA_EXTRA;

        if (accept)
        begin
            if (!failed_reg)
            begin
                if (pos_reg == POS_START)
                begin
                    if (chars.character != CHAR_COLON)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else
                begin
                    acc_next = acc_shift;
                    if (pos_reg == POS_COUNT_DONE)
                    begin
                        count_next = acc_shift[7:0];
                        sum_next   = sum_reg + acc_shift[7:0];
                        acc_next   = '0;
                    end
                    else if (pos_reg == POS_ADDR_DONE)
                    begin
                        addr_next = acc_shift;
                        sum_next  = sum_reg + acc_shift[7:0] + acc_shift[15:8];
                        acc_next  = '0;
                    end
                    else if (pos_reg == POS_TYPE_DONE)
                    begin
                        type_next = acc_shift[7:0];
                        sum_next  = sum_reg + acc_shift[7:0];
                        acc_next  = '0;
                        if (acc_shift[7:0] == REC_EOF)
                        begin
                            end_next = 1'b1;
                        end
                    end
                    else if (pos_reg > POS_TYPE_DONE)
                    begin
                        if (type_reg == REC_DATA)
                        begin
                            // second digit of a byte pair
                            if (pos_off[0])
                            begin
                                acc_next = '0;
                                if (pair < (POS_W-1)'(count_reg))
                                begin
                                    sum_next   = sum_reg + pair_byte;
                                    index_next = index_reg + 8'd1;
                                    emit_data  = 1'b1;
                                end
                                else if (pair == (POS_W-1)'(count_reg))
                                begin
                                    sum_next = sum_reg + pair_byte;
                                end
                            end
                        end
                        else if (pos_reg == POS_BASE_DONE)
                        begin
                            if (type_reg == REC_SEGMENT)
                            begin
                                seg_next = acc_shift;
                            end
                            else if (type_reg == REC_EXTENDED)
                            begin
                                ext_next = acc_shift;
                            end
                            acc_next = '0;
                        end
                    end
                end
            end

            // saturating position count
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 10'd1;
            end

            // line status from the state after this character
            data_len = 10'({1'b0, count_next, 1'b0}) + LEN_DATA_EXTRA;
            if (failed_next)
            begin
                line_status = ST_NO_COLON;
            end
            else if (pos_next < LEN_HEADER)
            begin
                line_status = ST_CUT_OFF;
            end
            else if (type_next == REC_DATA)
            begin
                if (pos_next < data_len)
                begin
                    line_status = ST_CUT_OFF;
                end
                else if (sum_next != 8'h00)
                begin
                    line_status = ST_CHECKSUM;
                end
            end
            else if (type_next == REC_SEGMENT || type_next == REC_EXTENDED)
            begin
                if (pos_next < LEN_BASE_REC)
                begin
                    line_status = ST_CUT_OFF;
                end
            end
        end

        // result beats
        data_res.kind         = KIND_DATA;
        data_res.byte_address = base_addr;
        data_res.data_byte    = pair_byte;
        data_res.status       = ST_OK;
        data_res.record_type  = type_next;
        data_res.byte_count   = count_next;
        data_res.end_seen     = end_next;
        data_res.last_result  = ~chars.line_end;

        status_res.kind         = KIND_STATUS;
        status_res.byte_address = '0;
        status_res.data_byte    = '0;
        status_res.status       = line_status;
        status_res.record_type  = type_next;
        status_res.byte_count   = count_next;
        status_res.end_seen     = end_next;
        status_res.last_result  = 1'b1;

        // line end clears the per-line state
        if (accept && chars.line_end)
        begin
            pos_next    = '0;
            failed_next = 1'b0;
            count_next  = '0;
            addr_next   = '0;
            type_next   = '0;
            sum_next    = '0;
            acc_next    = '0;
            index_next  = '0;
        end
    end

    // beats pushed into the result queue
    always_comb
    begin
        wr_count  = 2'(emit_data) + 2'(accept & chars.line_end);
        wr_first  = emit_data ? data_res : status_res;
        wr_second = status_res;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            failed_reg <= 1'b0;
            count_reg  <= '0;
            addr_reg   <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
            acc_reg    <= '0;
            seg_reg    <= '0;
            ext_reg    <= '0;
            index_reg  <= '0;
            end_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            acc_reg    <= acc_next;
            seg_reg    <= seg_next;
            ext_reg    <= ext_next;
            index_reg  <= index_next;
            end_reg    <= end_next;
        end
    end

    // result queue and output side
    ihex_result_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_count  (wr_count),
        .wr_first  (wr_first),
        .wr_second (wr_second),
        .rd_en     (results.ready),
        .rd_data   (head),
        .rd_valid  (head_valid),
        .has_room  (queue_room)
    );

    assign results.valid        = head_valid;
    assign results.kind         = head.kind;
    assign results.byte_address = head.byte_address;
    assign results.data_byte    = head.data_byte;
    assign results.status       = head.status;
    assign results.record_type  = head.record_type;
    assign results.byte_count   = head.byte_count;
    assign results.end_seen     = head.end_seen;
    assign results.last_result  = head.last_result;

`ifndef NO_ASSERTIONS
    // every accepted line end queues a status beat
    a_line_end_status : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.line_end) |-> (wr_count != 2'd0))
        else $error("line end accepted without a status beat");

    // a line end restarts the position count
    a_line_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.line_end) |=> (pos_reg == POS_START))
        else $error("position not cleared after line end");

    // two beats only from a line end character
    a_two_beats : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_count == 2'd2) |-> (accept && chars.line_end && emit_data))
        else $error("two beats queued without a data line end");

    // the end-of-file flag is sticky
    a_end_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(end_reg))
        else $error("end-of-file flag dropped");
`endif

endmodule
